/* design/skf_pkg.sv */
package skf_pkg;

	// number format
	localparam int DW = 32;
	localparam int FW = 16;

	// derived widths
	localparam int MUL_W = 2 * DW + 1;
	localparam int SAT_W = 2 * DW - FW + 3;
	localparam int CNT_W = $clog2(DW);
	localparam int STEP_W = 4;
	localparam int PADDR_W = 4;

	typedef logic signed [DW-1:0] fx_t;
	typedef logic [STEP_W-1:0] step_t;

	localparam fx_t ONE_FX = fx_t'(1) << FW;

	localparam logic signed [SAT_W-1:0] SAT_HI = {{(SAT_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SAT_W-1:0] SAT_LO = {{(SAT_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

	// register map
	typedef enum logic [1:0] {
		REG_PROCESS_NOISE,
		REG_MEASUREMENT_NOISE,
		REG_INITIAL_COVARIANCE,
		REG_INITIAL_ESTIMATE
	} reg_idx_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_TAKE,
		OP_PRED,
		OP_DEN,
		OP_DIV_START,
		OP_GAIN,
		OP_MUL_EST,
		OP_EST_MUL_COV,
		OP_COV,
		OP_OUT
	} op_t;

	// sequencer conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_DIV_BUSY,
		C_DEN_ZERO,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t wait_on;
		cond_t jump_on;
		step_t target;
	} ucode_t;

	typedef struct packed {
		op_t  op;
		logic go;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic div_busy;
		logic den_zero;
		logic out_full;
	} seq_stat_t;

	typedef struct packed {
		logic          start;
		logic [DW-1:0] rem;
		logic [DW-1:0] num;
		logic [DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic          busy;
		logic [DW-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic load_p;
		logic load_x;
		fx_t  value;
	} cfg_load_t;

	// program steps
	localparam step_t STEP_TAKE = 4'd0;
	localparam step_t STEP_PRED = 4'd1;
	localparam step_t STEP_DEN = 4'd2;
	localparam step_t STEP_DIV_START = 4'd3;
	localparam step_t STEP_DIV_WAIT = 4'd4;
	localparam step_t STEP_GAIN = 4'd5;
	localparam step_t STEP_MUL_EST = 4'd6;
	localparam step_t STEP_EST = 4'd7;
	localparam step_t STEP_COV = 4'd8;
	localparam step_t STEP_OUT = 4'd9;

	// control store: hold while wait_on, else jump on jump_on, else next step
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t u;
		u = '{op: OP_NOP, wait_on: C_NEVER, jump_on: C_ALWAYS, target: STEP_TAKE};
		case (s)
			STEP_TAKE: u = '{op: OP_TAKE, wait_on: C_NO_INPUT, jump_on: C_NEVER,
				target: STEP_TAKE};
			STEP_PRED: u = '{op: OP_PRED, wait_on: C_NEVER, jump_on: C_NEVER,
				target: STEP_TAKE};
			STEP_DEN: u = '{op: OP_DEN, wait_on: C_NEVER, jump_on: C_NEVER,
				target: STEP_TAKE};
			STEP_DIV_START: u = '{op: OP_DIV_START, wait_on: C_NEVER, jump_on: C_DEN_ZERO,
				target: STEP_GAIN};
			STEP_DIV_WAIT: u = '{op: OP_NOP, wait_on: C_DIV_BUSY, jump_on: C_NEVER,
				target: STEP_TAKE};
			STEP_GAIN: u = '{op: OP_GAIN, wait_on: C_NEVER, jump_on: C_NEVER,
				target: STEP_TAKE};
			STEP_MUL_EST: u = '{op: OP_MUL_EST, wait_on: C_NEVER, jump_on: C_NEVER,
				target: STEP_TAKE};
			STEP_EST: u = '{op: OP_EST_MUL_COV, wait_on: C_NEVER, jump_on: C_NEVER,
				target: STEP_TAKE};
			STEP_COV: u = '{op: OP_COV, wait_on: C_NEVER, jump_on: C_NEVER,
				target: STEP_TAKE};
			STEP_OUT: u = '{op: OP_OUT, wait_on: C_OUT_FULL, jump_on: C_ALWAYS,
				target: STEP_TAKE};
			default: u = '{op: OP_NOP, wait_on: C_NEVER, jump_on: C_ALWAYS,
				target: STEP_TAKE};
		endcase
		return u;
	endfunction

	// clamp a wide signed value to the data range
	function automatic fx_t sat_fx(input logic signed [SAT_W-1:0] v);
		fx_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[DW-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[DW-1:0];
		end else begin
			r = v[DW-1:0];
		end
		return r;
	endfunction

endpackage

/* design/skf_ifs.sv */
interface skf_in_if import skf_pkg::*; ();
	logic valid;
	logic ready;
	fx_t  measurement;

	modport source (output valid, output measurement, input ready);
	modport sink (input valid, input measurement, output ready);
endinterface

interface skf_out_if import skf_pkg::*; ();
	logic valid;
	logic ready;
	fx_t  estimate;
	fx_t  gain;
	fx_t  covariance;
	logic divide_error;

	modport source (output valid, output estimate, output gain, output covariance,
		output divide_error, input ready);
	modport sink (input valid, input estimate, input gain, input covariance,
		input divide_error, output ready);
endinterface

/* design/skf_divider.sv */
module skf_divider import skf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    acc_q;

	logic [DW:0]   shifted;
	logic          take;
	logic [DW-1:0] rem_next;

	// one restoring step a cycle, remainder stays below the divisor
	assign shifted = {rem_q, acc_q[DW-1]};
	assign take = shifted >= {1'b0, den_q};
	always_comb begin
		rem_next = shifted[DW-1:0];
		if (take) begin
			rem_next = DW'(shifted - {1'b0, den_q});
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(DW - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// numerator shifts out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			acc_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_next;
			acc_q <= {acc_q[DW-2:0], take};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quot = acc_q;

endmodule

/* design/skf_sequencer.sv */
module skf_sequencer import skf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output ctrl_t     ctrl
);

	step_t  step_q;
	ucode_t uc;
	logic   wait_hit;
	logic   jump_hit;

	function automatic logic cond_eval(input cond_t c, input seq_stat_t s);
		logic r;
		case (c)
			C_NEVER: r = 1'b0;
			C_ALWAYS: r = 1'b1;
			C_NO_INPUT: r = !s.in_valid;
			C_DIV_BUSY: r = s.div_busy;
			C_DEN_ZERO: r = s.den_zero;
			C_OUT_FULL: r = s.out_full;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// control word fetch
	assign uc = ucode_rom(step_q);
	assign wait_hit = cond_eval(uc.wait_on, stat);
	assign jump_hit = cond_eval(uc.jump_on, stat);

	assign ctrl.op = uc.op;
	assign ctrl.go = !wait_hit;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_TAKE;
		end else if (!wait_hit) begin
			if (jump_hit) begin
				step_q <= uc.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

/* design/skf_datapath.sv */
module skf_datapath import skf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_t     ctrl,
	input  fx_t       process_noise,
	input  fx_t       measurement_noise,
	input  cfg_load_t cfg_load,
	input  div_rsp_t  div_rsp,
	output div_req_t  div_req,
	output seq_stat_t stat,
	skf_in_if.sink    meas,
	skf_out_if.source res
);

	// filter state
	fx_t x_q;
	fx_t p_q;

	// working registers
	fx_t                   z_q;
	fx_t                   pp_q;
	fx_t                   den_q;
	logic signed [DW:0]    diff_q;
	logic                  ovf_q;
	logic                  qneg_q;
	fx_t                   gain_q;
	logic                  err_q;
	logic [MUL_W-1:0]      mul_q;
	logic                  mneg_q;
	fx_t                   est_q;
	fx_t                   cov_q;

	// result register
	logic res_valid_q;
	fx_t  res_est_q;
	fx_t  res_gain_q;
	fx_t  res_cov_q;
	logic res_err_q;

	logic                  fire;
	logic                  den_zero;
	logic [DW-1:0]         pp_mag;
	logic [DW-1:0]         den_mag;
	logic [DW-1:0]         pp_hi;
	logic                  ovf_now;
	logic [DW:0]           diff_mag;
	logic [DW-1:0]         gain_mag;
	logic signed [DW:0]    onem;
	logic [DW:0]           onem_mag;
	logic [DW:0]           mul_a;
	logic [DW-1:0]         mul_b;
	logic [MUL_W-1:0]      mul_p;
	logic [MUL_W-FW-1:0]   mul_sh;
	logic signed [SAT_W-1:0] prod_s;
	logic signed [SAT_W-1:0] quot_s;
	fx_t                   gain_next;

	assign fire = ctrl.go;
	assign den_zero = (den_q == '0);

	// magnitudes
	assign pp_mag = pp_q[DW-1] ? DW'(~pp_q + 1'b1) : pp_q;
	assign den_mag = den_q[DW-1] ? DW'(~den_q + 1'b1) : den_q;
	assign diff_mag = diff_q[DW] ? (DW+1)'(~diff_q + 1'b1) : diff_q;
	assign gain_mag = gain_q[DW-1] ? DW'(~gain_q + 1'b1) : gain_q;
	assign onem = $signed({1'b0, ONE_FX}) - (DW+1)'(gain_q);
	assign onem_mag = onem[DW] ? (DW+1)'(~onem + 1'b1) : onem;

	// quotient of at least 2^DW saturates without running the divider
	assign pp_hi = pp_mag >> FW;
	assign ovf_now = pp_hi >= den_mag;

	assign div_req.start = fire && (ctrl.op == OP_DIV_START) && !den_zero && !ovf_now;
	assign div_req.rem = pp_hi;
	assign div_req.num = {pp_mag[FW-1:0], {(DW-FW){1'b0}}};
	assign div_req.den = den_mag;

	// signed gain from quotient
	assign quot_s = qneg_q ? -$signed(SAT_W'(div_rsp.quot)) : $signed(SAT_W'(div_rsp.quot));
	always_comb begin
		gain_next = sat_fx(quot_s);
		if (den_zero) begin
			gain_next = '0;
		end else if (ovf_q) begin
			gain_next = qneg_q ? SAT_LO[DW-1:0] : SAT_HI[DW-1:0];
		end
	end

	// shared multiplier
	always_comb begin
		mul_a = diff_mag;
		mul_b = gain_mag;
		if (ctrl.op == OP_EST_MUL_COV) begin
			mul_a = onem_mag;
			mul_b = pp_mag;
		end
	end
	assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
	assign mul_sh = mul_q[MUL_W-1:FW];
	assign prod_s = mneg_q ? -$signed(SAT_W'(mul_sh)) : $signed(SAT_W'(mul_sh));

	// working registers, one operation per step
	always_ff @(posedge clk) begin
		if (fire) begin
			case (ctrl.op)
				OP_TAKE: begin
					z_q <= meas.measurement;
				end
				OP_PRED: begin
					pp_q <= sat_fx(SAT_W'(p_q) + SAT_W'(process_noise));
				end
				OP_DEN: begin
					den_q <= sat_fx(SAT_W'(pp_q) + SAT_W'(measurement_noise));
					diff_q <= (DW+1)'(z_q) - (DW+1)'(x_q);
				end
				OP_DIV_START: begin
					ovf_q <= ovf_now;
					qneg_q <= pp_q[DW-1] ^ den_q[DW-1];
				end
				OP_GAIN: begin
					gain_q <= gain_next;
					err_q <= den_zero;
				end
				OP_MUL_EST: begin
					mul_q <= mul_p;
					mneg_q <= diff_q[DW] ^ gain_q[DW-1];
				end
				OP_EST_MUL_COV: begin
					est_q <= sat_fx(SAT_W'(x_q) + prod_s);
					mul_q <= mul_p;
					mneg_q <= onem[DW] ^ pp_q[DW-1];
				end
				OP_COV: begin
					cov_q <= sat_fx(prod_s);
				end
				OP_OUT: begin
					res_est_q <= est_q;
					res_gain_q <= gain_q;
					res_cov_q <= cov_q;
					res_err_q <= err_q;
				end
				default: begin
				end
			endcase
		end
	end

	// filter state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			p_q <= ONE_FX;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_load.load_p) begin
				p_q <= cfg_load.value;
			end else if (fire && (ctrl.op == OP_OUT)) begin
				p_q <= cov_q;
			end
			if (cfg_load.load_x) begin
				x_q <= cfg_load.value;
			end else if (fire && (ctrl.op == OP_OUT)) begin
				x_q <= est_q;
			end
			if (fire && (ctrl.op == OP_OUT)) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// sequencer status
	assign stat.in_valid = meas.valid;
	assign stat.div_busy = div_rsp.busy;
	assign stat.den_zero = den_zero;
	assign stat.out_full = res_valid_q && !res.ready;

	// channel ports
	assign meas.ready = (ctrl.op == OP_TAKE);
	assign res.valid = res_valid_q;
	assign res.estimate = res_est_q;
	assign res.gain = res_gain_q;
	assign res.covariance = res_cov_q;
	assign res.divide_error = res_err_q;

endmodule

/* design/scalar_kalman_filter.sv */
// scalar kalman filter, signed Q16.16 fixed point
//
// meas channel: one measurement per transfer (valid/ready). res channel: one
// result per measurement carrying estimate, gain, covariance and divide_error.
// the apb port holds process noise, measurement noise, initial covariance and
// initial estimate at byte addresses 0, 4, 8 and 12; writing either initial
// register also loads the filter state. write it only while the block is idle.
//
// a short microprogram steps a shared datapath; the gain is divided out by a
// restoring divider at one quotient bit a cycle, which sets the rate. each
// measurement is worked through to its result before the next one is taken.
// a zero denominator skips the divider and its wait step. a quotient of 2^32
// or more also skips the divider but passes the wait step.
//
// reset loads process noise 0, measurement noise 1.0, covariance 1.0 and
// estimate 0, and empties the result register. a result waits in its register
// while res.ready is low; the next measurement is still taken and worked on,
// and its result step holds until the earlier result has gone.
module scalar_kalman_filter import skf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	skf_in_if.sink             meas,
	skf_out_if.source          res
);

	fx_t process_noise_q;
	fx_t measurement_noise_q;
	fx_t initial_covariance_q;
	fx_t initial_estimate_q;

	reg_idx_t  reg_idx;
	logic      wr_en;
	cfg_load_t cfg_load;
	ctrl_t     ctrl;
	seq_stat_t stat;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_noise_q <= '0;
			measurement_noise_q <= ONE_FX;
			initial_covariance_q <= ONE_FX;
			initial_estimate_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PROCESS_NOISE: process_noise_q <= pwdata;
				REG_MEASUREMENT_NOISE: measurement_noise_q <= pwdata;
				REG_INITIAL_COVARIANCE: initial_covariance_q <= pwdata;
				REG_INITIAL_ESTIMATE: initial_estimate_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// state loads on the initial registers
	assign cfg_load.load_p = wr_en && (reg_idx == REG_INITIAL_COVARIANCE);
	assign cfg_load.load_x = wr_en && (reg_idx == REG_INITIAL_ESTIMATE);
	assign cfg_load.value = pwdata;

	// read back
	always_comb begin
		case (reg_idx)
			REG_PROCESS_NOISE: prdata = process_noise_q;
			REG_MEASUREMENT_NOISE: prdata = measurement_noise_q;
			REG_INITIAL_COVARIANCE: prdata = initial_covariance_q;
			REG_INITIAL_ESTIMATE: prdata = initial_estimate_q;
			default: prdata = '0;
		endcase
	end

	skf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	skf_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	skf_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.process_noise     (process_noise_q),
		.measurement_noise (measurement_noise_q),
		.cfg_load          (cfg_load),
		.div_rsp           (div_rsp),
		.div_req           (div_req),
		.stat              (stat),
		.meas              (meas),
		.res               (res)
	);

	// one measurement at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		meas.valid && meas.ready |=> !meas.ready)
		else $error("measurement taken on consecutive cycles");

	// no new measurement while a division is running
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> !meas.ready)
		else $error("measurement channel ready during division");

	// a divider start only from the start step
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (ctrl.op == OP_DIV_START) && !div_rsp.busy)
		else $error("divider started out of sequence");

	// zero denominator forces a zero gain
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.divide_error |-> (res.gain == '0))
		else $error("divide error with non-zero gain");

endmodule
